FILE: hw/rtl/assert_macros.svh
// assertion helpers, compiled out for synthesis
// the using scope provides clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/kmde_pkg.sv
package kmde_pkg;

    localparam int ROWS        = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] DEFAULT_DEBOUNCE = 8'd5;
    localparam logic [7:0] COUNT_MAX        = 8'hFF;

    typedef struct packed {
        logic       keyboard_sel;
        logic [2:0] column_sel;
        logic [7:0] row_bits;
    } kmde_in_t;

    typedef struct packed {
        logic       event_keyboard;
        logic [5:0] event_key;
        logic       event_down;
        logic       event_last;
    } kmde_out_t;

    // per (manual, column) state word
    typedef struct packed {
        logic [ROWS-1:0]       stable;
        logic [ROWS-1:0][7:0]  counts;
        logic [ROWS-1:0]       mask;
    } kmde_entry_t;

    localparam kmde_entry_t ENTRY_RESET = '{
        stable: '0,
        counts: '0,
        mask:   '1
    };

    // events of one reading, handed from front to back
    typedef struct packed {
        logic            keyboard;
        logic [2:0]      column;
        logic [ROWS-1:0] events;
        logic [ROWS-1:0] down;
    } kmde_job_t;

endpackage

FILE: hw/rtl/kmde_ram.sv
module kmde_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/kmde_front.sv
module kmde_front
    import kmde_pkg::*;
#(
    parameter int NUM_MANUALS = 2,
    parameter int NUM_COLUMNS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  kmde_in_t           in_item,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic [LEVEL_W-1:0] queue_level,
    output logic               job_push,
    output kmde_job_t          job
);

    localparam int DEPTH  = NUM_MANUALS * NUM_COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]        debounce_reg;
    logic              f1_valid_reg;
    logic [ADDR_W-1:0] f1_addr_reg;
    kmde_in_t          f1_item_reg;
    logic              wr_valid_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    kmde_entry_t       wr_data_reg;
    logic [DEPTH-1:0]  entry_valid_reg;

    logic              accept;
    logic              in_range;
    logic [ADDR_W-1:0] rd_addr;
    logic [$bits(kmde_entry_t)-1:0] ram_rd_data;
    kmde_entry_t       entry_cur;
    kmde_entry_t       entry_new;
    logic [ROWS-1:0]   ev;
    logic [ROWS-1:0]   down;

    // leave room in the queue for the reading in flight and the one coming in
    assign full   = (int'(queue_level) + int'(f1_valid_reg)) >= QUEUE_DEPTH;
    assign accept = push && !full;

    assign in_range = (int'(in_item.keyboard_sel) < NUM_MANUALS)
                   && (int'(in_item.column_sel) < NUM_COLUMNS);
    assign rd_addr  = ADDR_W'(int'(in_item.keyboard_sel) * NUM_COLUMNS
                              + int'(in_item.column_sel));

    kmde_ram
    #(
        .WIDTH ($bits(kmde_entry_t)),
        .DEPTH (DEPTH)
    )
    u_state_ram
    (
        .clk     (clk),
        .wr_en   (f1_valid_reg),
        .wr_addr (f1_addr_reg),
        .wr_data (entry_new),
        .rd_en   (accept && in_range),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // the ram read may miss the write of the reading just before
    always_comb
    begin
        if (wr_valid_reg && (wr_addr_reg == f1_addr_reg))
        begin
            entry_cur = wr_data_reg;
        end
        else if (!entry_valid_reg[f1_addr_reg])
        begin
            entry_cur = ENTRY_RESET;
        end
        else
        begin
            entry_cur = kmde_entry_t'(ram_rd_data);
        end
    end

    always_comb
    begin
        logic       pressed;
        logic [7:0] cnt_inc;
        entry_new = entry_cur;
        ev        = '0;
        down      = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            pressed = !f1_item_reg.row_bits[r];
            cnt_inc = (entry_cur.counts[r] == COUNT_MAX) ? COUNT_MAX
                                                          : entry_cur.counts[r] + 8'd1;
            down[r] = pressed;
            if (pressed == entry_cur.stable[r])
            begin
                entry_new.counts[r] = '0;
            end
            else if (cnt_inc < debounce_reg)
            begin
                entry_new.counts[r] = cnt_inc;
            end
            else
            begin
                entry_new.counts[r] = '0;
                entry_new.stable[r] = pressed;
                // mask bit set means the key is not sounding
                if (pressed && entry_cur.mask[r])
                begin
                    entry_new.mask[r] = 1'b0;
                    ev[r]             = 1'b1;
                end
                else if (!pressed && !entry_cur.mask[r])
                begin
                    entry_new.mask[r] = 1'b1;
                    ev[r]             = 1'b1;
                end
            end
        end
    end

    assign job_push     = f1_valid_reg && (ev != '0);
    assign job.keyboard = f1_item_reg.keyboard_sel;
    assign job.column   = f1_item_reg.column_sel;
    assign job.events   = ev;
    assign job.down     = down;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= DEFAULT_DEBOUNCE;
            f1_valid_reg    <= 1'b0;
            wr_valid_reg    <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                debounce_reg <= cfg_wr_data;
            end
            f1_valid_reg <= accept && in_range;
            if (f1_valid_reg)
            begin
                wr_valid_reg                 <= 1'b1;
                entry_valid_reg[f1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_addr_reg <= rd_addr;
            f1_item_reg <= in_item;
        end
        if (f1_valid_reg)
        begin
            wr_addr_reg <= f1_addr_reg;
            wr_data_reg <= entry_new;
        end
    end

endmodule

FILE: hw/rtl/kmde_queue.sv
module kmde_queue
    import kmde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kmde_job_t          push_job,
    input  logic               pop,
    output kmde_job_t          head_job,
    output logic               empty,
    output logic [LEVEL_W-1:0] level
);

    kmde_job_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic               do_pop;

    assign empty    = (level_reg == '0);
    assign level    = level_reg;
    assign head_job = slot_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    always_comb
    begin
        level_next = level_reg;
        if (push && !do_pop)
        begin
            level_next = level_reg + LEVEL_W'(1);
        end
        else if (!push && do_pop)
        begin
            level_next = level_reg - LEVEL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (push)
            begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                                     : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                                     : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hw/rtl/kmde_back.sv
module kmde_back
    import kmde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  kmde_job_t head_job,
    input  logic      queue_empty,
    output logic      queue_pop,
    output logic      empty,
    input  logic      pop,
    output kmde_out_t out_item
);

    logic      cur_valid_reg;
    logic      cur_valid_next;
    kmde_job_t cur_job_reg;
    kmde_job_t cur_job_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    kmde_out_t out_reg;
    kmde_out_t out_next;

    kmde_job_t       src_job;
    logic            src_valid;
    logic            slot_free;
    logic            emit;
    logic [2:0]      row_idx;
    logic [ROWS-1:0] rem_after;

    // a partly sent job takes precedence over the queue head
    assign src_valid = cur_valid_reg || !queue_empty;
    assign src_job   = cur_valid_reg ? cur_job_reg : head_job;
    assign slot_free = !out_valid_reg || pop;
    assign emit      = src_valid && slot_free;
    assign queue_pop = emit && !cur_valid_reg;

    // lowest pending row goes first
    always_comb
    begin
        row_idx = '0;
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (src_job.events[r])
            begin
                row_idx = 3'(r);
            end
        end
    end

    assign rem_after = src_job.events & ~(ROWS'(1) << row_idx);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next          = 1'b1;
            out_next.event_keyboard = src_job.keyboard;
            out_next.event_key      = {src_job.column, row_idx};
            out_next.event_down     = src_job.down[row_idx];
            out_next.event_last     = (rem_after == '0);
            cur_valid_next          = (rem_after != '0);
            cur_job_next            = src_job;
            cur_job_next.events     = rem_after;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg <= cur_job_next;
        out_reg     <= out_next;
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

endmodule

FILE: hw/rtl/key_matrix_debounce_events.sv
// path: a reading is registered in the state stage, its events pass the job queue, and the
// event sequencer registers them onto the result ports; throughput: one column reading per
// cycle while full is low; a reading's events leave one by one, each held until popped
// the four-entry job queue between state update and event sequencer sets when full rises
// reset: all keys released, counters clear, nothing sounding, debounce count 5;
// state words come up through per-entry valid bits, so there is no clearing pass
`include "assert_macros.svh"

module key_matrix_debounce_events
    import kmde_pkg::*;
#(
    parameter int NUM_MANUALS = 2,
    parameter int NUM_COLUMNS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  kmde_in_t   in_item,
    output logic       empty,
    input  logic       pop,
    output kmde_out_t  out_item,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic               job_push;
    kmde_job_t          job;
    kmde_job_t          head_job;
    logic               queue_empty;
    logic               queue_pop;
    logic [LEVEL_W-1:0] queue_level;

    kmde_front
    #(
        .NUM_MANUALS (NUM_MANUALS),
        .NUM_COLUMNS (NUM_COLUMNS)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .queue_level (queue_level),
        .job_push    (job_push),
        .job         (job)
    );

    kmde_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (queue_pop),
        .head_job (head_job),
        .empty    (queue_empty),
        .level    (queue_level)
    );

    kmde_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .queue_empty (queue_empty),
        .queue_pop   (queue_pop),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item)
    );

    `ASSERT_ALWAYS(a_queue_bound, int'(queue_level) <= QUEUE_DEPTH)

    `ASSERT_IMPLIES(a_full_at_capacity, int'(queue_level) == QUEUE_DEPTH, full)

    // the rest of a burst follows without a gap
    `ASSERT_NEXT(a_burst_continues, pop && !empty && !out_item.event_last, !empty)

    `ASSERT_IMPLIES(a_no_push_into_full_queue,
                    job_push, int'(queue_level) < QUEUE_DEPTH || queue_pop)

endmodule
